### rtl/crr_pkg.sv
// Shared constants for the camera ray rotation block: trig formats, sine polynomial, register map.
package crr_pkg;

	// Sine and cosine are signed Q1.14 values in [-16384, 16384].
	localparam int TRIG_W   = 16;
	// Binary angles are brought to a 16-bit phase before the sine lookup.
	localparam int PHASE_W  = 16;
	// Quarter turn at the 16-bit phase, also 1.0 in Q14.
	localparam int QTR      = 16384;
	// Half of one Q14 unit, used for round-to-nearest.
	localparam int RND_HALF = 8192;

	// Coefficients of the quarter-wave sine polynomial.
	localparam int SIN_C2   = 2320;
	localparam int SIN_C1   = 21024;
	localparam int SIN_C0   = 51472;

	// Pipeline depth of the sine unit; new angles settle once they have passed through all its stages.
	localparam int TRIG_LAT = 5;
	localparam int SETTLE_W = $clog2(TRIG_LAT + 1);

	// Configuration port.
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;
	localparam logic REG_PITCH = 1'b0;
	localparam logic REG_YAW   = 1'b1;

endpackage

### rtl/crr_sine.sv
// Five-stage pipelined Q1.14 sine of a 16-bit phase.
module crr_sine import crr_pkg::*; (
	input  logic                     clk,
	input  logic [PHASE_W-1:0]       phase,
	output logic signed [TRIG_W-1:0] sine
);

	logic [1:0]  q_s1, q_s2, q_s3, q_s4;
	logic [14:0] t_s1, t_s2, t_s3;
	logic [28:0] tt_s1;
	logic [14:0] t2_s2;
	logic [26:0] p2_s2;
	logic [29:0] p3_s3;
	logic [30:0] p4_s4;
	logic signed [TRIG_W-1:0] sine_s5;

	logic [13:0] frac;
	logic [14:0] t_c;
	logic [29:0] tt_rnd;
	logic [14:0] t2_c;
	logic [26:0] p2_rnd;
	logic [14:0] inner_c;
	logic [29:0] p3_rnd;
	logic [15:0] mid_c;
	logic [30:0] p4_rnd;
	logic [15:0] s_mag;

	always_comb begin
		frac    = phase[13:0];
		// Odd quadrants run the quarter wave backwards.
		t_c     = phase[14] ? (15'(QTR) - {1'b0, frac}) : {1'b0, frac};
		tt_rnd  = {1'b0, tt_s1} + 30'(RND_HALF);
		t2_c    = tt_rnd[28:14];
		p2_rnd  = p2_s2 + 27'(RND_HALF);
		inner_c = 15'(SIN_C1) - {3'b000, p2_rnd[25:14]};
		p3_rnd  = p3_s3 + 30'(RND_HALF);
		mid_c   = 16'(SIN_C0) - {1'b0, p3_rnd[28:14]};
		p4_rnd  = p4_s4 + 31'(QTR);
		s_mag   = p4_rnd[30:15];
	end

	always_ff @(posedge clk) begin
		q_s1    <= phase[15:14];
		t_s1    <= t_c;
		tt_s1   <= 29'(t_c) * 29'(t_c);

		q_s2    <= q_s1;
		t_s2    <= t_s1;
		t2_s2   <= t2_c;
		p2_s2   <= 27'(t2_c) * 27'(SIN_C2);

		q_s3    <= q_s2;
		t_s3    <= t_s2;
		p3_s3   <= 30'(t2_s2) * 30'(inner_c);

		q_s4    <= q_s3;
		p4_s4   <= 31'(t_s3) * 31'(mid_c);

		// The lower half turn is positive, the upper half negative.
		sine_s5 <= q_s4[1] ? -$signed(s_mag) : $signed(s_mag);
	end

	assign sine = sine_s5;

endmodule

### rtl/crr_rot_cell.sv
// One plane-rotation cell: u = a*c + b*s, v = b*c - a*s, rounded to the input format.
module crr_rot_cell import crr_pkg::*; #(
	parameter int IW = 16,
	parameter int PW = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_vld,
	output logic                     in_rdy,
	input  logic signed [IW-1:0]     a,
	input  logic signed [IW-1:0]     b,
	input  logic [PW-1:0]            pass_in,
	input  logic signed [TRIG_W-1:0] cos_v,
	input  logic signed [TRIG_W-1:0] sin_v,
	output logic                     out_vld,
	input  logic                     out_rdy,
	output logic signed [IW+1:0]     u,
	output logic signed [IW+1:0]     v,
	output logic [PW-1:0]            pass_out
);

	localparam int PRW = IW + TRIG_W;
	localparam int SW  = PRW + 1;

	logic                  vld_s1, vld_s2;
	logic                  adv1, adv2;
	logic signed [PRW-1:0] p_ac_s1, p_bs_s1, p_as_s1, p_bc_s1;
	logic [PW-1:0]         pass_s1, pass_s2;
	logic signed [IW+1:0]  u_s2, v_s2;
	logic signed [SW-1:0]  sum_u, sum_v;

	// A stage moves when it is empty or its successor takes its beat.
	assign adv2   = !vld_s2 || out_rdy;
	assign adv1   = !vld_s1 || adv2;
	assign in_rdy = adv1;

	always_comb begin
		sum_u = SW'(p_ac_s1) + SW'(p_bs_s1) + SW'(RND_HALF);
		sum_v = SW'(p_bc_s1) - SW'(p_as_s1) + SW'(RND_HALF);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_vld;
			if (adv2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_vld) begin
			p_ac_s1 <= a * cos_v;
			p_bs_s1 <= b * sin_v;
			p_as_s1 <= a * sin_v;
			p_bc_s1 <= b * cos_v;
			pass_s1 <= pass_in;
		end
		if (adv2 && vld_s1) begin
			u_s2    <= sum_u[IW+15:14];
			v_s2    <= sum_v[IW+15:14];
			pass_s2 <= pass_s1;
		end
	end

	assign out_vld  = vld_s2;
	assign u        = u_s2;
	assign v        = v_s2;
	assign pass_out = pass_s2;

endmodule

### rtl/camera_ray_rotation.sv
// Top level of the camera ray rotation block: pitch then yaw rotation of one direction vector.
//
//   Channel   Signals                          Beat
//   dir       dir_valid, dir_stall             dir_x, dir_y, dir_z
//   rot       rot_valid, rot_stall             rot_x, rot_y, rot_z
//   config    psel, penable, pwrite, paddr     pitch_angle at 0x0, yaw_angle at 0x4
//
// The block accepts one beat per cycle while dir_stall is low; each result passes through
// the pitch cell stages, the yaw cell stages and the output register.
// Reset clears the angle registers to zero and the pipeline valid bits.
// After reset and after every angle write, dir_stall stays high while
// the sine pipelines settle on the new angles.
// A stall on rot only holds the stages that are full; empty stages keep filling, so
// the input keeps taking beats until the whole chain is occupied.
module camera_ray_rotation import crr_pkg::*; #(
	parameter int VEC_WIDTH   = 16,
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [APB_AW-1:0]           paddr,
	input  logic [APB_DW-1:0]           pwdata,
	output logic [APB_DW-1:0]           prdata,
	output logic                        pready,

	input  logic                        dir_valid,
	output logic                        dir_stall,
	input  logic signed [VEC_WIDTH-1:0] dir_x,
	input  logic signed [VEC_WIDTH-1:0] dir_y,
	input  logic signed [VEC_WIDTH-1:0] dir_z,

	output logic                        rot_valid,
	input  logic                        rot_stall,
	output logic signed [VEC_WIDTH-1:0] rot_x,
	output logic signed [VEC_WIDTH-1:0] rot_y,
	output logic signed [VEC_WIDTH-1:0] rot_z
);

	localparam int VW = VEC_WIDTH;
	localparam int AW = ANGLE_WIDTH;

	// Clamp a wide signed value to the VW-bit signed range.
	function automatic logic signed [VW-1:0] sat_vec(input logic signed [VW+3:0] val);
		logic [4:0] top;
		top = val[VW+3:VW-1];
		if (top == 5'b00000 || top == 5'b11111) begin
			return val[VW-1:0];
		end else if (val[VW+3]) begin
			return {1'b1, {(VW-1){1'b0}}};
		end else begin
			return {1'b0, {(VW-1){1'b1}}};
		end
	endfunction

	// Angle registers, written from the configuration port.
	logic [AW-1:0]       pitch_q, yaw_q;
	logic                wr_en;
	logic [SETTLE_W-1:0] settle_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= '0;
			yaw_q   <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_PITCH: pitch_q <= pwdata[AW-1:0];
				REG_YAW:   yaw_q   <= pwdata[AW-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_PITCH: prdata = APB_DW'(pitch_q);
			REG_YAW:   prdata = APB_DW'(yaw_q);
			default:   prdata = '0;
		endcase
	end

	// Input is held off until the sine pipelines reflect the current angles.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_W'(TRIG_LAT);
		end else if (wr_en) begin
			settle_q <= SETTLE_W'(TRIG_LAT);
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	// Binary angles become 16-bit phases: the top bits for wide angles, padded for narrow ones.
	logic [PHASE_W-1:0] pitch_ph, yaw_ph;

	generate
		if (AW >= PHASE_W) begin : g_phase_top
			assign pitch_ph = pitch_q[AW-1 -: PHASE_W];
			assign yaw_ph   = yaw_q[AW-1 -: PHASE_W];
		end else begin : g_phase_pad
			assign pitch_ph = {pitch_q, {(PHASE_W-AW){1'b0}}};
			assign yaw_ph   = {yaw_q, {(PHASE_W-AW){1'b0}}};
		end
	endgenerate

	// Cosine is the sine a quarter turn ahead.
	logic signed [TRIG_W-1:0] sin_p, cos_p, sin_w, cos_w;

	crr_sine u_sin_pitch (.clk(clk), .phase(pitch_ph), .sine(sin_p));
	crr_sine u_cos_pitch (.clk(clk), .phase(pitch_ph + PHASE_W'(QTR)), .sine(cos_p));
	crr_sine u_sin_yaw   (.clk(clk), .phase(yaw_ph), .sine(sin_w));
	crr_sine u_cos_yaw   (.clk(clk), .phase(yaw_ph + PHASE_W'(QTR)), .sine(cos_w));

	// Pitch cell rotates (y, z) about the x axis and carries x alongside.
	logic                  pitch_in_vld, pitch_in_rdy;
	logic                  pitch_out_vld, yaw_in_rdy;
	logic signed [VW+1:0]  y1, z1;
	logic [VW-1:0]         x_pass;

	assign pitch_in_vld = dir_valid && (settle_q == '0);
	assign dir_stall    = !pitch_in_rdy || (settle_q != '0);

	crr_rot_cell #(.IW(VW), .PW(VW)) u_pitch (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (pitch_in_vld),
		.in_rdy   (pitch_in_rdy),
		.a        (dir_y),
		.b        (dir_z),
		.pass_in  (dir_x),
		.cos_v    (cos_p),
		.sin_v    (sin_p),
		.out_vld  (pitch_out_vld),
		.out_rdy  (yaw_in_rdy),
		.u        (y1),
		.v        (z1),
		.pass_out (x_pass)
	);

	// Yaw cell rotates (x, z1) about the y axis; y1 is final and rides along saturated.
	// The intermediate z1 keeps its extra bits.
	logic                  yaw_out_vld, yaw_out_rdy;
	logic signed [VW+1:0]  x_ext;
	logic signed [VW-1:0]  y1_sat;
	logic signed [VW+3:0]  x2, z2;
	logic [VW-1:0]         y_pass;

	assign x_ext  = (VW+2)'($signed(x_pass));
	assign y1_sat = sat_vec((VW+4)'(y1));

	crr_rot_cell #(.IW(VW+2), .PW(VW)) u_yaw (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (pitch_out_vld),
		.in_rdy   (yaw_in_rdy),
		.a        (x_ext),
		.b        (z1),
		.pass_in  (y1_sat),
		.cos_v    (cos_w),
		.sin_v    (sin_w),
		.out_vld  (yaw_out_vld),
		.out_rdy  (yaw_out_rdy),
		.u        (x2),
		.v        (z2),
		.pass_out (y_pass)
	);

	// Output register with saturation of the two yaw results.
	logic                 rot_valid_q;
	logic signed [VW-1:0] rot_x_q, rot_y_q, rot_z_q;

	assign yaw_out_rdy = !rot_valid_q || !rot_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_valid_q <= 1'b0;
		end else if (yaw_out_rdy) begin
			rot_valid_q <= yaw_out_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (yaw_out_rdy && yaw_out_vld) begin
			rot_x_q <= sat_vec(x2);
			rot_y_q <= $signed(y_pass);
			rot_z_q <= sat_vec(z2);
		end
	end

	assign rot_valid = rot_valid_q;
	assign rot_x     = rot_x_q;
	assign rot_y     = rot_y_q;
	assign rot_z     = rot_z_q;

endmodule

### verif/tb.sv
// Self-checking testbench for camera_ray_rotation: random and edge-case rays under changing angles.
`timescale 1ns / 100ps

module tb import crr_pkg::*;;

	localparam int VEC_W      = 16;
	localparam int ANGLE_W    = 16;
	// Idle margin that lets the pipeline run empty, used before angle writes and at the end.
	localparam int DRAIN_TAIL = 10;
	// Timeout in clock cycles; the slowest legal run is far shorter than this.
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASES     = 12;
	localparam int RAYS_PER_PHASE = 142;
	localparam int EDGE_RAYS  = 20;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [VEC_W-1:0] z;
	} ray_t;

	// Holds its own copy of the two angles and the rays still expected on the rot channel.
	class rotation_scoreboard;
		logic [ANGLE_W-1:0] pitch;
		logic [ANGLE_W-1:0] yaw;
		ray_t pending_rot[$];
		int failures;

		function new();
			pitch = '0;
			yaw = '0;
			failures = 0;
		endfunction

		// Quarter-wave sine in Q14, t in [0, 16384].
		function longint quarter_wave(longint t);
			longint t2, inner, mid;
			t2 = (t * t + RND_HALF) >>> 14;
			inner = SIN_C1 - ((t2 * SIN_C2 + RND_HALF) >>> 14);
			mid = SIN_C0 - ((t2 * inner + RND_HALF) >>> 14);
			return (t * mid + QTR) >>> 15;
		endfunction

		// With 16-bit angles the phase is the angle itself.
		function longint sine_q14(logic [PHASE_W-1:0] ph);
			longint t, s;
			t = ph[14] ? longint'(QTR) - longint'(ph[13:0]) : longint'(ph[13:0]);
			s = quarter_wave(t);
			return ph[15] ? -s : s;
		endfunction

		function longint cosine_q14(logic [PHASE_W-1:0] ph);
			logic [PHASE_W-1:0] shifted;
			shifted = ph + PHASE_W'(QTR);
			return sine_q14(shifted);
		endfunction

		function longint round_q14(longint v);
			return (v + RND_HALF) >>> 14;
		endfunction

		function longint clamp_vec(longint v);
			longint hi, lo;
			hi = (longint'(1) <<< (VEC_W - 1)) - 1;
			lo = -hi - 1;
			if (v > hi) return hi;
			if (v < lo) return lo;
			return v;
		endfunction

		// Pitch about x first, then yaw about y. The intermediate z keeps its extra bit.
		function ray_t rotate_vector(ray_t d);
			longint x, y, z, cp, sp, cw, sw, y1, z1, x2, z2;
			ray_t r;
			x = $signed(d.x);
			y = $signed(d.y);
			z = $signed(d.z);
			cp = cosine_q14(pitch);
			sp = sine_q14(pitch);
			cw = cosine_q14(yaw);
			sw = sine_q14(yaw);
			y1 = clamp_vec(round_q14(y * cp + z * sp));
			z1 = round_q14(-y * sp + z * cp);
			x2 = clamp_vec(round_q14(x * cw + z1 * sw));
			z2 = clamp_vec(round_q14(-x * sw + z1 * cw));
			r.x = x2[VEC_W-1:0];
			r.y = y1[VEC_W-1:0];
			r.z = z2[VEC_W-1:0];
			return r;
		endfunction

		function void note_direction(ray_t d);
			pending_rot.push_back(rotate_vector(d));
		endfunction

		task report(string what, longint got, longint want);
			$display("%0t ns: rot mismatch on %s: got %0d, expected %0d", $time, what, got, want);
			failures++;
		endtask

		task check_rotation(ray_t got);
			ray_t want;
			if (pending_rot.size() == 0) begin
				$display("%0t ns: rot beat (%0d, %0d, %0d) arrived with nothing expected",
					$time, got.x, got.y, got.z);
				failures++;
			end else begin
				want = pending_rot.pop_front();
				if (got.x !== want.x) report("rot_x", $signed(got.x), $signed(want.x));
				if (got.y !== want.y) report("rot_y", $signed(got.y), $signed(want.y));
				if (got.z !== want.z) report("rot_z", $signed(got.z), $signed(want.z));
			end
		endtask
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [APB_AW-1:0]       paddr;
	logic [APB_DW-1:0]       pwdata;
	logic [APB_DW-1:0]       prdata;
	logic                    pready;
	logic                    dir_valid;
	logic                    dir_stall;
	logic signed [VEC_W-1:0] dir_x;
	logic signed [VEC_W-1:0] dir_y;
	logic signed [VEC_W-1:0] dir_z;
	logic                    rot_valid;
	logic                    rot_stall;
	logic signed [VEC_W-1:0] rot_x;
	logic signed [VEC_W-1:0] rot_y;
	logic signed [VEC_W-1:0] rot_z;

	rotation_scoreboard sb;
	// When set, neither side inserts gaps or stalls: the closing stretch runs at full rate.
	bit quiet;
	int cycle_count = 0;

	camera_ray_rotation #(
		.VEC_WIDTH(VEC_W),
		.ANGLE_WIDTH(ANGLE_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.dir_valid(dir_valid),
		.dir_stall(dir_stall),
		.dir_x(dir_x),
		.dir_y(dir_y),
		.dir_z(dir_z),
		.rot_valid(rot_valid),
		.rot_stall(rot_stall),
		.rot_x(rot_x),
		.rot_y(rot_y),
		.rot_z(rot_z)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost beat ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// All inputs and outputs are sampled right after the edge, before any
	// nonblocking update of that edge lands, so the values seen are the ones
	// the block saw when it decided whether to move a beat.
	always @(posedge clk) begin
		if (arst_n && rot_valid && !rot_stall)
			sb.check_rotation(ray_t'{x: rot_x, y: rot_y, z: rot_z});
	end

	// Back-pressure on the result side: random stall bursts separated by
	// free stretches, none at all once the run turns quiet.
	initial begin
		rot_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (quiet || $urandom_range(0, 2) != 0) begin
				rot_stall <= 1'b0;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end else begin
				rot_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	// Mostly uniform components, with a fair share of the extremes so that
	// saturation and the wide intermediate z are hit often.
	function automatic logic signed [VEC_W-1:0] pick_component();
		unique case ($urandom_range(0, 9))
			0: return {1'b0, {(VEC_W-1){1'b1}}};
			1: return {1'b1, {(VEC_W-1){1'b0}}};
			2: return VEC_W'($urandom_range(0, 3)) - VEC_W'(2);
			default: return VEC_W'($urandom);
		endcase
	endfunction

	// Offers one beat on dir, sometimes after an idle burst, and holds it until taken.
	task automatic send_dir(ray_t d);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			dir_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		dir_valid <= 1'b1;
		dir_x <= d.x;
		dir_y <= d.y;
		dir_z <= d.z;
		do
			@(posedge clk);
		while (dir_stall);
		sb.note_direction(d);
	endtask

	// APB write with a setup phase and an access phase, then the bus goes idle. The upper data
	// bits are random; the block must drop them.
	task automatic write_angle(logic reg_idx, logic [ANGLE_W-1:0] angle);
		logic [APB_DW-1:0] word;
		word = $urandom;
		word[ANGLE_W-1:0] = angle;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({reg_idx, 2'b00});
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_idx == REG_PITCH)
			sb.pitch = angle;
		else
			sb.yaw = angle;
		@(posedge clk);
	endtask

	// Waits until every expected beat has come back, then lets the pipeline run empty.
	task automatic drain_rot();
		while (sb.pending_rot.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	// Field extremes, single axes, sign flips and the combinations that push
	// the pitch stage and the yaw stage into saturation.
	int edge_rays[EDGE_RAYS][3] = '{
		'{0, 0, 0},
		'{32767, 32767, 32767},
		'{-32768, -32768, -32768},
		'{32767, -32768, 0},
		'{-32768, 32767, -1},
		'{1, -1, 1},
		'{-1, 1, -1},
		'{8192, 0, 0},
		'{0, 8192, 0},
		'{0, 0, 8192},
		'{-8192, -8192, 8192},
		'{32767, 0, -32768},
		'{0, 32767, 32767},
		'{0, -32768, 32767},
		'{-32768, -32768, 32767},
		'{32767, 32767, -32768},
		'{-32768, 0, 0},
		'{0, -32768, 0},
		'{21845, -10923, 5461},
		'{-21846, 10922, -5462}
	};

	initial begin
		logic [ANGLE_W-1:0] next_pitch;
		logic [ANGLE_W-1:0] next_yaw;
		ray_t r;

		sb = new();
		quiet = 1'b0;
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		dir_valid <= 1'b0;
		dir_x <= '0;
		dir_y <= '0;
		dir_z <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase 0 runs on the reset angles; each later phase first rewrites both
		// angles with the pipeline empty. An eighth turn, the top code, quadrant
		// boundaries and codes beside them come first, then random angles.
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				unique case (ph)
					1: begin next_pitch = 16'd8192;  next_yaw = 16'd8192;  end
					2: begin next_pitch = 16'hFFFF;  next_yaw = 16'hFFFF;  end
					3: begin next_pitch = 16'd16384; next_yaw = 16'd49152; end
					4: begin next_pitch = 16'd32768; next_yaw = 16'd32768; end
					5: begin next_pitch = 16'd49152; next_yaw = 16'd0;     end
					6: begin next_pitch = 16'd1;     next_yaw = 16'd65534; end
					default: begin
						next_pitch = ANGLE_W'($urandom);
						next_yaw = ANGLE_W'($urandom);
					end
				endcase
				drain_rot();
				write_angle(REG_PITCH, next_pitch);
				write_angle(REG_YAW, next_yaw);
			end
			quiet = (ph >= PHASES - 2);

			// The directed rays run at zero angles and again at 45 degrees on both
			// axes, where the unsaturated intermediate z matters most.
			if (ph < 2) begin
				for (int i = 0; i < EDGE_RAYS; i++) begin
					r.x = VEC_W'(edge_rays[i][0]);
					r.y = VEC_W'(edge_rays[i][1]);
					r.z = VEC_W'(edge_rays[i][2]);
					send_dir(r);
				end
			end

			repeat (RAYS_PER_PHASE) begin
				r.x = pick_component();
				r.y = pick_component();
				r.z = pick_component();
				send_dir(r);
			end
			dir_valid <= 1'b0;
		end

		drain_rot();
		if (sb.failures == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

### files.f
rtl/crr_pkg.sv
rtl/crr_sine.sv
rtl/crr_rot_cell.sv
rtl/camera_ray_rotation.sv
verif/tb.sv
